// ----- rtl/core/bounded_list_edit_engine_core_macros.svh -----
// assertion macros for the bounded list edit engine core
// used by the top level only; no dependencies
`ifndef BOUNDED_LIST_EDIT_ENGINE_CORE_MACROS_SVH
`define BOUNDED_LIST_EDIT_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BLEE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blee check failed");
// next-cycle implication
`define BLEE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blee check failed");
`else
`define BLEE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BLEE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/blee_pkg.sv -----
// shared types and constants of the bounded list edit engine
// no dependencies
package blee_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int FUNC_W    = 3;
  localparam int WORD_W    = 64;
  localparam int IDX_W     = 6;
  localparam int STAT_W    = 3;
  localparam int LEN_W     = 7;

  typedef enum logic [FUNC_W-1:0] {
    F_APPEND   = 3'd0,
    F_RM_FIRST = 3'd1,
    F_RM_ALL   = 3'd2,
    F_WRITE    = 3'd3,
    F_DUMP     = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    S_OK      = 3'd0,
    S_FULL    = 3'd1,
    S_NOMATCH = 3'd2,
    S_RANGE   = 3'd3,
    S_EMPTY   = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [WORD_W-1:0]  value;
    logic [IDX_W-1:0]   index;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0]  data;
    logic               last;
    status_t            status;
    logic [LEN_W-1:0]   length;
  } out_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic               shift;
    logic               wr;
    logic [IDX_W-1:0]   wpos;
    logic [WORD_W-1:0]  wdata;
  } cell_ctl_t;

endpackage

// ----- rtl/core/bounded_list_edit_engine_core.sv -----
// top level of the bounded list edit engine: control, counters and the row of cells
// depends on blee_pkg, blee_cell and bounded_list_edit_engine_core_macros.svh
//
// channel  | ports                       | handshake
// ---------+-----------------------------+--------------------------------
// input    | start, busy, in_item        | beat taken when start && !busy
// result   | out_valid, out_item         | one-cycle strobe, no back-pressure
//
// append, write-at-index, unused codes, empty-list walks: result in the cycle after
// the beat, next beat may follow at once. remove-first, remove-all and dump on a list
// of n entries rotate the row once through cell 0, one entry a cycle, busy all
// the while; a dump emits one beat per cycle, a remove answers after the last step.
// reset clears the count and control only; cell contents are unknown until written.
`include "bounded_list_edit_engine_core_macros.svh"

module bounded_list_edit_engine_core #(
  parameter int DEPTH = blee_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  blee_pkg::in_t    in_item,
  output logic             out_valid,
  output blee_pkg::out_t   out_item
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [blee_pkg::WORD_W-1:0] cell_q [DEPTH];
  blee_pkg::cell_ctl_t         ctl;

  blee_pkg::state_t            state_r, state_nxt;
  blee_pkg::func_t             op_r, op_nxt;
  logic [blee_pkg::WORD_W-1:0] value_r, value_nxt;
  logic [CntW-1:0]             count_r, count_nxt;
  logic [CntW-1:0]             rem_r, rem_nxt;
  logic                        found_r, found_nxt;
  logic                        out_valid_r, out_valid_nxt;
  blee_pkg::out_t              out_r, out_nxt;

  logic                        accept;
  logic                        walk_op;
  logic [blee_pkg::WORD_W-1:0] head;
  logic                        drop;
  logic [CntW-1:0]             count_m1;

  assign accept   = start && !busy;
  assign busy     = (state_r != blee_pkg::ST_IDLE);
  assign head     = cell_q[0];
  assign count_m1 = count_r - 1'b1;
  assign walk_op  = (in_item.func == blee_pkg::F_RM_FIRST) ||
                    (in_item.func == blee_pkg::F_RM_ALL) ||
                    (in_item.func == blee_pkg::F_DUMP);

  // head word leaves the row when it is the match being removed
  assign drop = (state_r == blee_pkg::ST_WALK) && (head == value_r) &&
                ((op_r == blee_pkg::F_RM_ALL) ||
                 ((op_r == blee_pkg::F_RM_FIRST) && !found_r));

  // row of cells, each takes its right neighbour on a shift
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [blee_pkg::WORD_W-1:0] right_d;
    if (g == DEPTH - 1) begin : g_end
      assign right_d = head;
    end else begin : g_mid
      assign right_d = cell_q[g+1];
    end
    blee_cell #(.CellIdx(g)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .right_d (right_d),
      .q       (cell_q[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      blee_pkg::ST_IDLE: begin
        if (accept && walk_op && (count_r != '0)) begin
          state_nxt = blee_pkg::ST_WALK;
        end
      end
      blee_pkg::ST_WALK: begin
        if (rem_r == CntW'(1)) begin
          state_nxt = blee_pkg::ST_IDLE;
        end
      end
      default: state_nxt = blee_pkg::ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    ctl           = '0;
    op_nxt        = op_r;
    value_nxt     = value_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      blee_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt         = in_item.func;
          value_nxt      = in_item.value;
          rem_nxt        = count_r;
          found_nxt      = 1'b0;
          ctl.wdata      = in_item.value;
          out_nxt.data   = '0;
          out_nxt.last   = 1'b1;
          out_nxt.status = blee_pkg::S_OK;
          out_valid_nxt  = 1'b1;
          unique case (in_item.func)
            blee_pkg::F_APPEND: begin
              if (count_r != CntW'(DEPTH)) begin
                ctl.wr    = 1'b1;
                ctl.wpos  = blee_pkg::IDX_W'(count_r);
                count_nxt = count_r + 1'b1;
              end else begin
                out_nxt.status = blee_pkg::S_FULL;
              end
            end
            blee_pkg::F_RM_FIRST, blee_pkg::F_RM_ALL: begin
              if (count_r == '0) begin
                out_nxt.status = blee_pkg::S_NOMATCH;
              end else begin
                out_valid_nxt = 1'b0;
              end
            end
            blee_pkg::F_WRITE: begin
              if (blee_pkg::LEN_W'(in_item.index) < blee_pkg::LEN_W'(count_r)) begin
                ctl.wr   = 1'b1;
                ctl.wpos = in_item.index;
              end else begin
                out_nxt.status = blee_pkg::S_RANGE;
              end
            end
            blee_pkg::F_DUMP: begin
              if (count_r == '0) begin
                out_nxt.status = blee_pkg::S_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
              end
            end
            default: ;
          endcase
          out_nxt.length = blee_pkg::LEN_W'(count_nxt);
        end
      end
      blee_pkg::ST_WALK: begin
        // rotate: head re-enters at the tail unless dropped
        ctl.shift = 1'b1;
        ctl.wr    = !drop;
        ctl.wpos  = blee_pkg::IDX_W'(count_m1);
        ctl.wdata = head;
        rem_nxt   = rem_r - 1'b1;
        if (drop) begin
          count_nxt = count_m1;
          found_nxt = 1'b1;
        end
        priority if (op_r == blee_pkg::F_DUMP) begin
          out_valid_nxt  = 1'b1;
          out_nxt.data   = head;
          out_nxt.last   = (rem_r == CntW'(1));
          out_nxt.status = blee_pkg::S_OK;
          out_nxt.length = blee_pkg::LEN_W'(count_r);
        end else if (rem_r == CntW'(1)) begin
          out_valid_nxt  = 1'b1;
          out_nxt.data   = '0;
          out_nxt.last   = 1'b1;
          out_nxt.status = (found_r || drop) ? blee_pkg::S_OK : blee_pkg::S_NOMATCH;
          out_nxt.length = blee_pkg::LEN_W'(count_nxt);
        end else begin
          out_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blee_pkg::ST_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    value_r <= value_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `BLEE_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CntW'(DEPTH))
  `BLEE_ASSERT_NXT(a_walk_no_grow, clk, rst_n, state_r == blee_pkg::ST_WALK, count_r <= $past(count_r))
  `BLEE_ASSERT_NXT(a_remove_quiet, clk, rst_n, (state_r == blee_pkg::ST_WALK) && (op_r != blee_pkg::F_DUMP) && (rem_r != CntW'(1)), !out_valid_r)
  `BLEE_ASSERT_NXT(a_single_answer, clk, rst_n, accept && (state_nxt == blee_pkg::ST_IDLE), out_valid_r && out_r.last)

endmodule

// ----- rtl/core/blee_cell.sv -----
// one storage cell of the list row: holds a word, takes its right neighbour on a shift
// depends on blee_pkg
module blee_cell #(
  parameter int CellIdx = 0
) (
  input  logic                           clk,
  input  blee_pkg::cell_ctl_t            ctl,
  input  logic [blee_pkg::WORD_W-1:0]    right_d,
  output logic [blee_pkg::WORD_W-1:0]    q
);

  logic [blee_pkg::WORD_W-1:0] word_r;
  logic [blee_pkg::WORD_W-1:0] word_nxt;
  logic                        sel;

  assign sel = ctl.wr && (ctl.wpos == blee_pkg::IDX_W'(CellIdx));

  always_comb begin
    priority if (sel) begin
      word_nxt = ctl.wdata;
    end else if (ctl.shift) begin
      word_nxt = right_d;
    end else begin
      word_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule
